@@ hdl/xcr_pkg.sv @@
// Shared types and constants for the XMODEM checksum receiver.
`default_nettype none

package xcr_pkg;

    // Line control bytes
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_CAN = 8'h18;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // Block geometry
    localparam int BLOCK_BYTES = 128;
    localparam int IDX_W = $clog2(BLOCK_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);

    // Request codes on the input channel
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    // Byte classes found by the front end
    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_SOH = 2'd1;
    localparam logic [1:0] CLS_EOT = 2'd2;
    localparam logic [1:0] CLS_CAN = 2'd3;

    // Block verdicts
    localparam logic [1:0] VERDICT_NONE = 2'd0;
    localparam logic [1:0] VERDICT_COMMIT = 2'd1;
    localparam logic [1:0] VERDICT_DISCARD = 2'd2;

    // Session status
    localparam logic [1:0] STATUS_RUNNING = 2'd0;
    localparam logic [1:0] STATUS_EOT = 2'd1;
    localparam logic [1:0] STATUS_CAN = 2'd2;
    localparam logic [1:0] STATUS_RETRIES = 2'd3;

    // Receive phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HUNT = 3'd1;
    localparam logic [2:0] PH_NUM = 3'd2;
    localparam logic [2:0] PH_COMP = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SUM = 3'd5;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_RETRY_LIMIT = 1'b0;
    localparam logic [3:0] RETRY_LIMIT_RESET = 4'd10;

    // Classified word passed from the front end to the back end
    typedef struct packed {
        logic [1:0] req;
        logic [1:0] cls;
        logic [7:0] data;
    } item_t;

endpackage

`default_nettype wire

@@ hdl/xcr_front.sv @@
// Front end: accepts input words and classifies them for the queue.
`default_nettype none

module xcr_front
(
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    req_type,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          queue_full,
    output logic               push,
    output xcr_pkg::item_t     item
);

    logic [1:0] cls;

    always_comb
    begin
        unique if (rx_byte == xcr_pkg::BYTE_SOH)
            cls = xcr_pkg::CLS_SOH;
        else if (rx_byte == xcr_pkg::BYTE_EOT)
            cls = xcr_pkg::CLS_EOT;
        else if (rx_byte == xcr_pkg::BYTE_CAN)
            cls = xcr_pkg::CLS_CAN;
        else
            cls = xcr_pkg::CLS_OTHER;
    end

    assign in_ready = !queue_full;
    assign push = in_valid && !queue_full;
    assign item = '{req: req_type, cls: cls, data: rx_byte};

endmodule

`default_nettype wire

@@ hdl/xcr_queue.sv @@
// Short first-in first-out queue of classified words between front and back.
`default_nettype none

module xcr_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire xcr_pkg::item_t    push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output xcr_pkg::item_t         head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    xcr_pkg::item_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // A pop from an empty queue would replay a stale word
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> !full)
        else $error("queue pushed while full");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && pop |=> $stable(count_reg))
        else $error("queue count moved on simultaneous push and pop");

endmodule

`default_nettype wire

@@ hdl/xcr_back.sv @@
// Back end: session state machine, block checks and the output register.
`default_nettype none

module xcr_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [3:0]        retry_limit,
    input  wire logic              item_valid,
    input  wire xcr_pkg::item_t    item,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   reply_valid,
    output logic [7:0]             reply_byte,
    output logic                   data_valid,
    output logic [7:0]             data_byte,
    output logic [1:0]             block_verdict,
    output logic [1:0]             session_status,
    output logic [15:0]            blocks_received
);

    localparam int IDX_W = xcr_pkg::IDX_W;

    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        expected_reg, expected_next;
    logic [7:0]        header_reg, header_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [7:0]        sum_reg, sum_next;
    logic [3:0]        retry_reg, retry_next;
    logic [15:0]       committed_reg, committed_next;

    logic              out_valid_reg, out_valid_next;
    logic              reply_valid_reg;
    logic [7:0]        reply_byte_reg;
    logic              data_valid_reg;
    logic [7:0]        data_byte_reg;
    logic [1:0]        verdict_reg;
    logic [1:0]        status_reg;
    logic [15:0]       blocks_reg;

    logic              emit;
    logic              e_reply;
    logic [7:0]        e_reply_byte;
    logic              e_data;
    logic [7:0]        e_data_byte;
    logic [1:0]        e_verdict;
    logic [1:0]        e_status;

    logic [3:0]        retry_inc;
    logic              fail_end;
    logic [2:0]        fail_phase;
    logic [1:0]        fail_status;
    logic              active;

    // Take a word only when the output register is free or being drained
    assign pop = item_valid && (!out_valid_reg || out_ready);

    assign retry_inc = retry_reg + 4'd1;
    assign fail_end = (retry_inc >= retry_limit);
    assign fail_phase = fail_end ? xcr_pkg::PH_IDLE : xcr_pkg::PH_HUNT;
    assign fail_status = fail_end ? xcr_pkg::STATUS_RETRIES : xcr_pkg::STATUS_RUNNING;
    assign active = (phase_reg != xcr_pkg::PH_IDLE) && (phase_reg <= xcr_pkg::PH_SUM);

    always_comb
    begin
        phase_next = phase_reg;
        expected_next = expected_reg;
        header_next = header_reg;
        index_next = index_reg;
        sum_next = sum_reg;
        retry_next = retry_reg;
        committed_next = committed_reg;
        emit = 1'b0;
        e_reply = 1'b0;
        e_reply_byte = 8'd0;
        e_data = 1'b0;
        e_data_byte = 8'd0;
        e_verdict = xcr_pkg::VERDICT_NONE;
        e_status = xcr_pkg::STATUS_RUNNING;

        if (pop)
        begin
            unique case (item.req)
                xcr_pkg::REQ_START:
                begin
                    phase_next = xcr_pkg::PH_HUNT;
                    expected_next = 8'd1;
                    header_next = 8'd0;
                    index_next = '0;
                    sum_next = 8'd0;
                    retry_next = 4'd0;
                    committed_next = 16'd0;
                    emit = 1'b1;
                    e_reply = 1'b1;
                    e_reply_byte = xcr_pkg::BYTE_NAK;
                end
                xcr_pkg::REQ_TIMEOUT:
                begin
                    if (active)
                    begin
                        retry_next = retry_inc;
                        phase_next = fail_phase;
                        emit = 1'b1;
                        e_reply = 1'b1;
                        e_reply_byte = xcr_pkg::BYTE_NAK;
                        e_status = fail_status;
                        if (phase_reg == xcr_pkg::PH_DATA || phase_reg == xcr_pkg::PH_SUM)
                            e_verdict = xcr_pkg::VERDICT_DISCARD;
                    end
                end
                xcr_pkg::REQ_BYTE:
                begin
                    unique case (phase_reg)
                        xcr_pkg::PH_HUNT:
                        begin
                            if (item.cls == xcr_pkg::CLS_SOH)
                                phase_next = xcr_pkg::PH_NUM;
                            else if (item.cls == xcr_pkg::CLS_EOT
                                     || item.cls == xcr_pkg::CLS_CAN)
                            begin
                                phase_next = xcr_pkg::PH_IDLE;
                                emit = 1'b1;
                                e_reply = 1'b1;
                                e_reply_byte = xcr_pkg::BYTE_ACK;
                                e_status = (item.cls == xcr_pkg::CLS_EOT)
                                    ? xcr_pkg::STATUS_EOT : xcr_pkg::STATUS_CAN;
                            end
                        end
                        xcr_pkg::PH_NUM:
                        begin
                            header_next = item.data;
                            phase_next = xcr_pkg::PH_COMP;
                        end
                        xcr_pkg::PH_COMP:
                        begin
                            if ((item.data ^ xcr_pkg::BYTE_ONES) != header_reg)
                            begin
                                retry_next = retry_inc;
                                phase_next = fail_phase;
                                emit = 1'b1;
                                e_reply = 1'b1;
                                e_reply_byte = xcr_pkg::BYTE_NAK;
                                e_status = fail_status;
                            end
                            else
                            begin
                                index_next = '0;
                                sum_next = 8'd0;
                                phase_next = xcr_pkg::PH_DATA;
                            end
                        end
                        xcr_pkg::PH_DATA:
                        begin
                            sum_next = sum_reg + item.data;
                            if (index_reg == xcr_pkg::LAST_IDX)
                            begin
                                index_next = '0;
                                phase_next = xcr_pkg::PH_SUM;
                            end
                            else
                                index_next = index_reg + 1'b1;
                            emit = 1'b1;
                            e_data = 1'b1;
                            e_data_byte = item.data;
                        end
                        xcr_pkg::PH_SUM:
                        begin
                            emit = 1'b1;
                            if (header_reg != expected_reg)
                            begin
                                // Wrong block number: discard silently
                                retry_next = retry_inc;
                                phase_next = fail_phase;
                                e_verdict = xcr_pkg::VERDICT_DISCARD;
                                e_status = fail_status;
                            end
                            else if (sum_reg == item.data)
                            begin
                                expected_next = expected_reg + 8'd1;
                                retry_next = 4'd0;
                                if (committed_reg != 16'hFFFF)
                                    committed_next = committed_reg + 16'd1;
                                phase_next = xcr_pkg::PH_HUNT;
                                e_reply = 1'b1;
                                e_reply_byte = xcr_pkg::BYTE_ACK;
                                e_verdict = xcr_pkg::VERDICT_COMMIT;
                            end
                            else
                            begin
                                retry_next = retry_inc;
                                phase_next = fail_phase;
                                e_reply = 1'b1;
                                e_reply_byte = xcr_pkg::BYTE_NAK;
                                e_verdict = xcr_pkg::VERDICT_DISCARD;
                                e_status = fail_status;
                            end
                        end
                        default:
                        begin
                            // Idle: drop the byte
                        end
                    endcase
                end
                xcr_pkg::REQ_NONE:
                begin
                    // Unused request code: drop
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (pop)
            out_valid_next = emit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= xcr_pkg::PH_IDLE;
            expected_reg <= 8'd1;
            header_reg <= 8'd0;
            index_reg <= '0;
            sum_reg <= 8'd0;
            retry_reg <= 4'd0;
            committed_reg <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            expected_reg <= expected_next;
            header_reg <= header_next;
            index_reg <= index_next;
            sum_reg <= sum_next;
            retry_reg <= retry_next;
            committed_reg <= committed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            reply_valid_reg <= e_reply;
            reply_byte_reg <= e_reply_byte;
            data_valid_reg <= e_data;
            data_byte_reg <= e_data_byte;
            verdict_reg <= e_verdict;
            status_reg <= e_status;
            blocks_reg <= committed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign reply_valid = reply_valid_reg;
    assign reply_byte = reply_byte_reg;
    assign data_valid = data_valid_reg;
    assign data_byte = data_byte_reg;
    assign block_verdict = verdict_reg;
    assign session_status = status_reg;
    assign blocks_received = blocks_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && out_valid_reg && !out_ready))
        else $error("output word overwritten while stalled");

    a_commit_acks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg == xcr_pkg::VERDICT_COMMIT
        |-> reply_valid_reg && reply_byte_reg == xcr_pkg::BYTE_ACK)
        else $error("commit without ACK");

    a_data_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && data_valid_reg
        |-> !reply_valid_reg && verdict_reg == xcr_pkg::VERDICT_NONE
            && status_reg == xcr_pkg::STATUS_RUNNING)
        else $error("data word carries control fields");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        pop && item.req != xcr_pkg::REQ_START |=>
            committed_reg == $past(committed_reg)
            || committed_reg == $past(committed_reg) + 16'd1)
        else $error("committed count jumped");

endmodule

`default_nettype wire

@@ hdl/xmodem_checksum_receiver.sv @@
// Top level: XMODEM checksum receiver with configuration port.
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_ready     req_type, rx_byte
// output    out_valid / out_ready   reply_valid .. blocks_received
// config    psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// One word per cycle sustained unless the output stalls; back-end state updates on each pop.
// An accepted word is written to a queue slot, then leaves the queue and enters
// the output register at the same edge; an output stall keeps it in the queue.
// The queue of QUEUE_DEPTH words absorbs output stalls; in_ready drops when full.
// Reset clears the session to idle, expected block 1 and retry limit 10.

module xmodem_checksum_receiver
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        req_type,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   reply_valid,
    output logic [7:0]                             reply_byte,
    output logic                                   data_valid,
    output logic [7:0]                             data_byte,
    output logic [1:0]                             block_verdict,
    output logic [1:0]                             session_status,
    output logic [15:0]                            blocks_received,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [xcr_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [xcr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [xcr_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    logic [3:0]        retry_limit_reg, retry_limit_next;
    logic              reg_sel;
    logic              push;
    logic              queue_full;
    logic              queue_not_empty;
    logic              pop;
    xcr_pkg::item_t    push_item;
    xcr_pkg::item_t    head_item;

    assign pready = 1'b1;
    assign reg_sel = (paddr[2] == xcr_pkg::REG_RETRY_LIMIT);

    always_comb
    begin
        retry_limit_next = retry_limit_reg;
        if (psel && penable && pwrite && reg_sel)
            retry_limit_next = pwdata[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            retry_limit_reg <= xcr_pkg::RETRY_LIMIT_RESET;
        else
            retry_limit_reg <= retry_limit_next;
    end

    assign prdata = reg_sel ? {28'd0, retry_limit_reg} : '0;

    xcr_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .item       (push_item)
    );

    xcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head_item)
    );

    xcr_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .retry_limit     (retry_limit_reg),
        .item_valid      (queue_not_empty),
        .item            (head_item),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .reply_valid     (reply_valid),
        .reply_byte      (reply_byte),
        .data_valid      (data_valid),
        .data_byte       (data_byte),
        .block_verdict   (block_verdict),
        .session_status  (session_status),
        .blocks_received (blocks_received)
    );

endmodule

`default_nettype wire
